>>> sv/lpcm_dp_pkg.sv
// Shared types and constants for the LPCM depacketizer with stereo output.
package lpcm_dp_pkg;

    localparam int MAX_CHANNELS_DEF = 8;

    // packet header formats
    localparam logic [1:0] FMT_BLURAY = 2'd0;
    localparam logic [1:0] FMT_DVD    = 2'd1;
    localparam logic [1:0] FMT_1394   = 2'd2;

    // sample width codes
    localparam logic [1:0] WID_16 = 2'd0;
    localparam logic [1:0] WID_20 = 2'd1;
    localparam logic [1:0] WID_24 = 2'd2;

    // sample rate codes
    localparam logic [2:0] RATE_48K  = 3'd0;
    localparam logic [2:0] RATE_96K  = 3'd1;
    localparam logic [2:0] RATE_192K = 3'd2;
    localparam logic [2:0] RATE_44K1 = 3'd3;
    localparam logic [2:0] RATE_32K  = 3'd4;

    localparam logic [3:0] CHS_DEF = 4'd2;

    // 0.707 in Q15
    localparam logic [14:0] Q15_GAIN = 15'd23167;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } t_in;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic [2:0]         rate_code;
        logic [1:0]         width_code;
        logic [3:0]         channel_count;
        logic               header_error;
    } t_out;

    // one complete frame handed from the parser to the mixer
    typedef struct packed {
        logic signed [15:0] c0;
        logic signed [15:0] c1;
        logic signed [17:0] sum_l;
        logic signed [17:0] sum_r;
        logic [3:0]         chs;
        logic [2:0]         rate;
        logic [1:0]         width;
        logic               err;
    } t_frm;

endpackage

>>> sv/lpcm_depacketizer_stereo.sv
// LPCM packet depacketizer: header decode, frame gathering and stereo downmix.
//
// Input channel: one packet byte per transfer (i_in_valid / o_in_stall), with
// packet_start set on the first header byte. i_cfg_we writes the header format
// (Blu-ray, DVD, IEEE1394); write it only while the block is idle.
// Output channel: one stereo frame per complete input frame (o_out_valid /
// i_out_stall), carrying the current rate, width, channel count and error flag.
// Throughput: one byte per cycle, sustained while no stall comes back from
// the output. Each byte passes an input register, the parse stage (header
// decode or sample capture) and the mixer stage (one Q15 multiply per side);
// a frame goes from the frame register into the mixer register to the output.
// A stall at the output fills the mixer register, then the frame register,
// then the input register; only after that is o_in_stall raised.
// Reset (i_rst_n low at a clock edge) empties all stages and restores 16 bit,
// 48 kHz, two channels and the Blu-ray format. No clearing pass is needed.
module lpcm_depacketizer_stereo #(
    parameter int MAX_CHANNELS = lpcm_dp_pkg::MAX_CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lpcm_dp_pkg::t_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lpcm_dp_pkg::t_out  o_out_data
);

    logic               frm_valid;
    logic               frm_stall;
    lpcm_dp_pkg::t_frm  frm;

    lpcm_dp_parse #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_frm_valid (frm_valid),
        .i_frm_stall (frm_stall),
        .o_frm       (frm)
    );

    lpcm_dp_mix u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frm_valid (frm_valid),
        .o_frm_stall (frm_stall),
        .i_frm       (frm),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> sv/lpcm_dp_parse.sv
// Header parser and frame gatherer: one byte per cycle to frames unless stalled.
module lpcm_dp_parse #(
    parameter int MAX_CHANNELS = lpcm_dp_pkg::MAX_CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lpcm_dp_pkg::t_in   i_in_data,
    output logic               o_frm_valid,
    input  logic               i_frm_stall,
    output lpcm_dp_pkg::t_frm  o_frm
);

    localparam int IDXW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    typedef struct packed {
        logic [1:0] width;
        logic [2:0] rate;
        logic [3:0] chs;
        logic       err;
    } t_hdr;

    function automatic t_hdr dec_bluray(input logic [31:0] h);
        t_hdr d;
        d.err = 1'b0;
        unique case (h[7:6])
            2'd1:    d.width = lpcm_dp_pkg::WID_16;
            2'd2:    d.width = lpcm_dp_pkg::WID_20;
            2'd3:    d.width = lpcm_dp_pkg::WID_24;
            default: begin d.width = lpcm_dp_pkg::WID_16; d.err = 1'b1; end
        endcase
        unique case (h[11:8])
            4'd1:    d.rate = lpcm_dp_pkg::RATE_48K;
            4'd4:    d.rate = lpcm_dp_pkg::RATE_96K;
            4'd5:    d.rate = lpcm_dp_pkg::RATE_192K;
            default: begin d.rate = lpcm_dp_pkg::RATE_48K; d.err = 1'b1; end
        endcase
        unique case (h[15:12])
            4'h1:        d.chs = 4'd1;
            4'h3:        d.chs = 4'd2;
            4'h4, 4'h5:  d.chs = 4'd3;
            4'h6, 4'h7:  d.chs = 4'd4;
            4'h8:        d.chs = 4'd5;
            4'h9:        d.chs = 4'd6;
            4'hA:        d.chs = 4'd7;
            4'hB:        d.chs = 4'd8;
            default:     begin d.chs = lpcm_dp_pkg::CHS_DEF; d.err = 1'b1; end
        endcase
        return d;
    endfunction

    function automatic t_hdr dec_1394(input logic [31:0] h);
        t_hdr d;
        d.width = lpcm_dp_pkg::WID_16;
        d.chs   = lpcm_dp_pkg::CHS_DEF;
        d.err   = (h[7:6] != 2'd0) || (h[2:0] > 3'd1);
        unique case (h[5:3])
            3'd1:    d.rate = lpcm_dp_pkg::RATE_44K1;
            3'd2:    d.rate = lpcm_dp_pkg::RATE_48K;
            default: begin d.rate = lpcm_dp_pkg::RATE_48K; d.err = 1'b1; end
        endcase
        return d;
    endfunction

    logic [1:0]             r_fmt;
    logic                   r_in_v;
    lpcm_dp_pkg::t_in       r_in;
    logic [39:0]            r_shift,  n_shift;
    logic [2:0]             r_hbc,    n_hbc;
    logic [1:0]             r_width,  n_width;
    logic [2:0]             r_rate,   n_rate;
    logic [3:0]             r_chs,    n_chs;
    logic                   r_err,    n_err;
    logic [31:0]            r_last,   n_last;
    logic [2:0]             r_sidx,   n_sidx;
    logic [1:0]             r_sbyte,  n_sbyte;
    logic [7:0]             r_hold,   n_hold;
    logic signed [15:0]     r_store [MAX_CHANNELS];
    logic                   r_frm_v;
    lpcm_dp_pkg::t_frm      r_frm;

    logic                   proc_go;
    logic                   in_ready;
    logic                   do_step;
    logic [2:0]             hdr_len;
    logic [2:0]             hbc_e;
    logic [39:0]            shift_e;
    logic [39:0]            shift_new;
    logic [2:0]             hbc_new;
    logic [2:0]             sidx_e;
    logic [1:0]             sbyte_e;
    logic [1:0]             sbyte_last;
    logic                   is_hdr;
    logic                   wr;
    logic [15:0]            wr_data;
    logic                   emit;
    logic [31:0]            h_dvd;
    t_hdr                   hdr;
    logic signed [15:0]     ch_val [8];

    assign proc_go    = !r_frm_v || !i_frm_stall;
    assign in_ready   = !r_in_v || proc_go;
    assign do_step    = r_in_v && proc_go;
    assign o_in_stall = !in_ready;

    always_comb begin
        unique case (r_fmt)
            lpcm_dp_pkg::FMT_BLURAY, lpcm_dp_pkg::FMT_1394: hdr_len = 3'd4;
            lpcm_dp_pkg::FMT_DVD:                           hdr_len = 3'd5;
            default:                                        hdr_len = 3'd0;
        endcase
        // a packet mark restarts header and frame gathering
        hbc_e     = r_in.packet_start ? 3'd0  : r_hbc;
        shift_e   = r_in.packet_start ? 40'd0 : r_shift;
        sidx_e    = r_in.packet_start ? 3'd0  : r_sidx;
        sbyte_e   = r_in.packet_start ? 2'd0  : r_sbyte;
        is_hdr    = hbc_e < hdr_len;
        shift_new = {shift_e[31:0], r_in.data_byte};
        hbc_new   = hbc_e + 3'd1;
        h_dvd     = {8'h00, shift_new[23:22], 6'h00, shift_new[15:0]};
        sbyte_last = (r_width == lpcm_dp_pkg::WID_16) ? 2'd1 : 2'd2;
        wr        = !is_hdr && (sbyte_e == 2'd1) && (32'(sidx_e) < MAX_CHANNELS);
        wr_data   = {r_hold, r_in.data_byte};
        hdr       = (r_fmt == lpcm_dp_pkg::FMT_BLURAY) ? dec_bluray(shift_new[31:0])
                                                       : dec_1394(shift_new[31:0]);

        n_shift = r_shift;
        n_hbc   = r_hbc;
        n_width = r_width;
        n_rate  = r_rate;
        n_chs   = r_chs;
        n_err   = r_err;
        n_last  = r_last;
        n_sidx  = r_sidx;
        n_sbyte = r_sbyte;
        n_hold  = r_hold;
        emit    = 1'b0;

        if (is_hdr) begin
            n_shift = shift_new;
            n_hbc   = hbc_new;
            n_sidx  = 3'd0;
            n_sbyte = 2'd0;
            if (hbc_new == hdr_len) begin
                if (r_fmt == lpcm_dp_pkg::FMT_DVD) begin
                    if (h_dvd != r_last) begin
                        n_last = h_dvd;
                        n_err  = 1'b0;
                        priority if (h_dvd[15:14] == 2'b10) n_width = lpcm_dp_pkg::WID_24;
                        else if (h_dvd[15:14] == 2'b01)     n_width = lpcm_dp_pkg::WID_20;
                        else                                n_width = lpcm_dp_pkg::WID_16;
                        unique case (h_dvd[13:12])
                            2'd0:    n_rate = lpcm_dp_pkg::RATE_48K;
                            2'd1:    n_rate = lpcm_dp_pkg::RATE_96K;
                            2'd2:    n_rate = lpcm_dp_pkg::RATE_44K1;
                            default: n_rate = lpcm_dp_pkg::RATE_32K;
                        endcase
                    end
                    // DVD channel count is taken from every header
                    n_chs = {1'b0, shift_new[10:8]} + 4'd1;
                end else if (shift_new[31:0] != r_last) begin
                    n_last  = shift_new[31:0];
                    n_width = hdr.width;
                    n_rate  = hdr.rate;
                    n_chs   = hdr.chs;
                    n_err   = hdr.err;
                end
            end
        end else begin
            n_shift = shift_e;
            n_hbc   = hbc_e;
            if (sbyte_e == 2'd0) begin
                n_hold = r_in.data_byte;
            end
            if (sbyte_e == sbyte_last) begin
                if ({1'b0, sidx_e} + 4'd1 == r_chs) begin
                    emit    = 1'b1;
                    n_sidx  = 3'd0;
                    n_sbyte = 2'd0;
                end else begin
                    n_sidx  = sidx_e + 3'd1;
                    n_sbyte = 2'd0;
                end
            end else begin
                n_sidx  = sidx_e;
                n_sbyte = sbyte_e + 2'd1;
            end
        end

        // frame channels, bypassing the sample being written this cycle
        for (int k = 0; k < 8; k++) begin
            ch_val[k] = 16'sd0;
        end
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            if (4'(k) < r_chs) begin
                ch_val[k] = (wr && (sidx_e == 3'(k))) ? $signed(wr_data)
                                                      : r_store[IDXW'(k)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= lpcm_dp_pkg::FMT_BLURAY;
            r_in_v  <= 1'b0;
            r_shift <= 40'd0;
            r_hbc   <= 3'd0;
            r_width <= lpcm_dp_pkg::WID_16;
            r_rate  <= lpcm_dp_pkg::RATE_48K;
            r_chs   <= lpcm_dp_pkg::CHS_DEF;
            r_err   <= 1'b0;
            r_last  <= 32'd0;
            r_sidx  <= 3'd0;
            r_sbyte <= 2'd0;
            r_frm_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fmt <= i_cfg_data;
            end
            if (in_ready) begin
                r_in_v <= i_in_valid;
            end
            if (do_step) begin
                r_shift <= n_shift;
                r_hbc   <= n_hbc;
                r_width <= n_width;
                r_rate  <= n_rate;
                r_chs   <= n_chs;
                r_err   <= n_err;
                r_last  <= n_last;
                r_sidx  <= n_sidx;
                r_sbyte <= n_sbyte;
            end
            if (proc_go) begin
                r_frm_v <= do_step && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_in <= i_in_data;
        end
        if (do_step) begin
            r_hold <= n_hold;
            if (wr) begin
                r_store[sidx_e[IDXW-1:0]] <= $signed(wr_data);
            end
        end
        if (do_step && emit) begin
            r_frm.c0    <= ch_val[0];
            r_frm.c1    <= ch_val[1];
            r_frm.sum_l <= 18'(ch_val[2]) + 18'(ch_val[3]) + 18'(ch_val[6]);
            r_frm.sum_r <= 18'(ch_val[2]) + 18'(ch_val[4]) + 18'(ch_val[7]);
            r_frm.chs   <= r_chs;
            r_frm.rate  <= r_rate;
            r_frm.width <= r_width;
            r_frm.err   <= r_err;
        end
    end

    assign o_frm_valid = r_frm_v;
    assign o_frm       = r_frm;

endmodule

>>> sv/lpcm_dp_mix.sv
// Stereo mixer: mono duplicate, stereo pass, Q15 downmix with saturation; output register.
module lpcm_dp_mix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_frm_valid,
    output logic               o_frm_stall,
    input  lpcm_dp_pkg::t_frm  i_frm,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lpcm_dp_pkg::t_out  o_out_data
);

    // truncate toward zero by 2^15, then clamp to 16 bits
    function automatic logic signed [15:0] q15_sat(input logic signed [33:0] acc);
        logic signed [33:0] adj;
        logic signed [18:0] q;
        adj = acc[33] ? acc + 34'sd32767 : acc;
        q   = adj[33:15];
        priority if (q > 19'sd32767)   return 16'sh7FFF;
        else if (q < -19'sd32768)      return 16'sh8000;
        else                           return q[15:0];
    endfunction

    logic                   r_out_v;
    lpcm_dp_pkg::t_out      r_out;
    logic                   out_ready;
    logic signed [15:0]     gain_s;
    logic signed [33:0]     acc_l;
    logic signed [33:0]     acc_r;
    logic signed [15:0]     mix_l;
    logic signed [15:0]     mix_r;

    assign out_ready   = !r_out_v || !i_out_stall;
    assign o_frm_stall = !out_ready;
    assign gain_s      = $signed({1'b0, lpcm_dp_pkg::Q15_GAIN});

    always_comb begin
        acc_l = ($signed(34'(i_frm.c0)) <<< 15) + gain_s * i_frm.sum_l;
        acc_r = ($signed(34'(i_frm.c1)) <<< 15) + gain_s * i_frm.sum_r;
        priority if (i_frm.chs == 4'd1) begin
            mix_l = i_frm.c0;
            mix_r = i_frm.c0;
        end else if (i_frm.chs == 4'd2) begin
            mix_l = i_frm.c0;
            mix_r = i_frm.c1;
        end else begin
            mix_l = q15_sat(acc_l);
            mix_r = q15_sat(acc_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_ready) begin
            r_out_v <= i_frm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && i_frm_valid) begin
            r_out.left_sample   <= mix_l;
            r_out.right_sample  <= mix_r;
            r_out.rate_code     <= i_frm.rate;
            r_out.width_code    <= i_frm.width;
            r_out.channel_count <= i_frm.chs;
            r_out.header_error  <= i_frm.err;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

>>> verif/lpcm_depacketizer_stereo_test.sv
// Self-checking testbench for the LPCM depacketizer with stereo output.
`timescale 1ns / 1ps

module lpcm_depacketizer_stereo_test;

    localparam logic [1:0] FMT_RAW      = 2'd3;  // no header, payload only
    localparam int         CYCLE_LIMIT  = 300000;
    localparam int         DRAIN_CYCLES = 12;
    localparam int         PHASE_ITEMS  = 200;
    localparam int         MAX_SHOWN    = 10;
    localparam int         NUM_PHASES   = 8;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic i_cfg_we  = 1'b0;
    logic [1:0] i_cfg_data = lpcm_dp_pkg::FMT_BLURAY;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    lpcm_dp_pkg::t_in  i_in_data  = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    lpcm_dp_pkg::t_out o_out_data;

    lpcm_depacketizer_stereo DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- depacketizer predictor ----------------
    logic [1:0]  fmt_sel;
    logic [39:0] hdr_acc;
    int unsigned hdr_taken;
    logic [1:0]  cur_width;
    logic [2:0]  cur_rate;
    logic [3:0]  cur_chans;
    logic        cur_err;
    int unsigned frame_pos;
    logic [7:0]  msb_hold;
    logic [15:0] chan_word [0:7];
    logic [31:0] prev_hdr;

    lpcm_dp_pkg::t_out stereo_q [$];

    function automatic void depack_reset();
        fmt_sel   = lpcm_dp_pkg::FMT_BLURAY;
        hdr_acc   = '0;
        hdr_taken = 0;
        cur_width = lpcm_dp_pkg::WID_16;
        cur_rate  = lpcm_dp_pkg::RATE_48K;
        cur_chans = lpcm_dp_pkg::CHS_DEF;
        cur_err   = 1'b0;
        frame_pos = 0;
        msb_hold  = '0;
        prev_hdr  = '0;
        for (int k = 0; k < 8; k++) chan_word[k] = '0;
    endfunction

    function automatic int unsigned hdr_len(logic [1:0] f);
        case (f)
            lpcm_dp_pkg::FMT_BLURAY, lpcm_dp_pkg::FMT_1394: return 4;
            lpcm_dp_pkg::FMT_DVD:                           return 5;
            default:                                        return 0;
        endcase
    endfunction

    function automatic void decode_bd(logic [31:0] h);
        logic bad;
        bad = 1'b0;
        case (h[7:6])
            2'd1:    cur_width = lpcm_dp_pkg::WID_16;
            2'd2:    cur_width = lpcm_dp_pkg::WID_20;
            2'd3:    cur_width = lpcm_dp_pkg::WID_24;
            default: begin cur_width = lpcm_dp_pkg::WID_16; bad = 1'b1; end
        endcase
        case (h[11:8])
            4'd1:    cur_rate = lpcm_dp_pkg::RATE_48K;
            4'd4:    cur_rate = lpcm_dp_pkg::RATE_96K;
            4'd5:    cur_rate = lpcm_dp_pkg::RATE_192K;
            default: begin cur_rate = lpcm_dp_pkg::RATE_48K; bad = 1'b1; end
        endcase
        case (h[15:12])
            4'h1:       cur_chans = 4'd1;
            4'h3:       cur_chans = 4'd2;
            4'h4, 4'h5: cur_chans = 4'd3;
            4'h6, 4'h7: cur_chans = 4'd4;
            4'h8:       cur_chans = 4'd5;
            4'h9:       cur_chans = 4'd6;
            4'hA:       cur_chans = 4'd7;
            4'hB:       cur_chans = 4'd8;
            default:    begin cur_chans = lpcm_dp_pkg::CHS_DEF; bad = 1'b1; end
        endcase
        cur_err = bad;
    endfunction

    function automatic void decode_dvd(logic [31:0] h);
        case (h[15:14])
            2'd2:    cur_width = lpcm_dp_pkg::WID_24;
            2'd1:    cur_width = lpcm_dp_pkg::WID_20;
            default: cur_width = lpcm_dp_pkg::WID_16;
        endcase
        case (h[13:12])
            2'd0:    cur_rate = lpcm_dp_pkg::RATE_48K;
            2'd1:    cur_rate = lpcm_dp_pkg::RATE_96K;
            2'd2:    cur_rate = lpcm_dp_pkg::RATE_44K1;
            default: cur_rate = lpcm_dp_pkg::RATE_32K;
        endcase
        cur_err = 1'b0;
    endfunction

    function automatic void decode_1394(logic [31:0] h);
        logic bad;
        bad = (h[7:6] != 2'd0);
        cur_width = lpcm_dp_pkg::WID_16;
        if (h[5:3] == 3'd1) cur_rate = lpcm_dp_pkg::RATE_44K1;
        else if (h[5:3] == 3'd2) cur_rate = lpcm_dp_pkg::RATE_48K;
        else begin
            cur_rate = lpcm_dp_pkg::RATE_48K;
            bad = 1'b1;
        end
        cur_chans = lpcm_dp_pkg::CHS_DEF;
        if (h[2:0] > 3'd1) bad = 1'b1;
        cur_err = bad;
    endfunction

    function automatic void parse_hdr();
        logic [31:0] h;
        if (fmt_sel == lpcm_dp_pkg::FMT_DVD) begin
            h = hdr_acc[31:0] & 32'h00C0FFFF;
            if (h != prev_hdr) begin
                prev_hdr = h;
                decode_dvd(h);
            end
            // DVD takes the channel count from every header
            cur_chans = {1'b0, h[10:8]} + 4'd1;
        end else begin
            h = hdr_acc[31:0];
            if (h != prev_hdr) begin
                prev_hdr = h;
                if (fmt_sel == lpcm_dp_pkg::FMT_BLURAY) decode_bd(h);
                else decode_1394(h);
            end
        end
    endfunction

    function automatic longint chan_val(int unsigned k);
        logic signed [15:0] w;
        if (k >= 8 || k >= cur_chans) return 0;
        w = chan_word[k];
        return longint'(w);
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic depack_byte(lpcm_dp_pkg::t_in it);
        int unsigned hl, bps, chs, flen, sidx, sbyte;
        longint al, ar, lv, rv, gain;
        lpcm_dp_pkg::t_out res;
        gain = longint'(lpcm_dp_pkg::Q15_GAIN);
        if (it.packet_start) begin
            hdr_taken = 0;
            hdr_acc   = '0;
            frame_pos = 0;
        end
        hl = hdr_len(fmt_sel);
        if (hdr_taken < hl) begin
            hdr_acc = {hdr_acc[31:0], it.data_byte};
            hdr_taken++;
            frame_pos = 0;
            if (hdr_taken == hl) parse_hdr();
        end else begin
            bps = (cur_width == lpcm_dp_pkg::WID_16) ? 2 : 3;
            chs = 32'(cur_chans);
            if (chs < 1) chs = 1;
            if (chs > 8) chs = 8;
            flen  = bps * chs;
            sidx  = frame_pos / bps;
            sbyte = frame_pos % bps;
            // third byte of a wide sample is dropped
            if (sbyte == 0) msb_hold = it.data_byte;
            else if (sbyte == 1 && sidx < 8) chan_word[sidx] = {msb_hold, it.data_byte};
            if (frame_pos + 1 < flen) begin
                frame_pos++;
            end else begin
                frame_pos = 0;
                if (chs == 1) begin
                    lv = chan_val(0);
                    rv = lv;
                end else if (chs == 2) begin
                    lv = chan_val(0);
                    rv = chan_val(1);
                end else begin
                    al = 32768 * chan_val(0)
                       + gain * (chan_val(2) + chan_val(3) + chan_val(6));
                    ar = 32768 * chan_val(1)
                       + gain * (chan_val(2) + chan_val(4) + chan_val(7));
                    lv = clip16(al / 32768);
                    rv = clip16(ar / 32768);
                end
                res.left_sample   = lv[15:0];
                res.right_sample  = rv[15:0];
                res.rate_code     = cur_rate;
                res.width_code    = cur_width;
                res.channel_count = chs[3:0];
                res.header_error  = cur_err;
                stereo_q.push_back(res);
            end
        end
    endtask

    // ---------------- stimulus generation ----------------
    lpcm_dp_pkg::t_in byte_q [$];
    int unsigned bytes_queued = 0;
    logic [1:0]  gen_fmt = FMT_RAW;
    logic [7:0]  gen_hdr [0:4];
    int unsigned gen_bps = 2;
    int unsigned gen_chs = 2;

    task automatic push_byte(logic [7:0] b, logic s);
        lpcm_dp_pkg::t_in it;
        it.data_byte    = b;
        it.packet_start = s;
        byte_q.push_back(it);
        bytes_queued++;
    endtask

    task automatic push_sample(int unsigned mode, inout logic mark);
        logic [7:0] msb, lsb;
        int unsigned pick;
        pick = (mode < 2) ? mode : $urandom_range(0, 3);
        case (pick)
            0:       begin msb = 8'h7F; lsb = 8'hFF; end
            1:       begin msb = 8'h80; lsb = 8'h00; end
            default: begin
                msb = 8'($urandom_range(0, 255));
                lsb = 8'($urandom_range(0, 255));
            end
        endcase
        push_byte(msb, mark);
        mark = 1'b0;
        push_byte(lsb, 1'b0);
        if (gen_bps == 3) push_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic gen_packet(logic [1:0] f);
        logic [7:0]  hb [0:4];
        int unsigned nhdr, nfr, tail, k, j, mode;
        logic        noisy, mark;
        noisy = ($urandom_range(0, 9) == 0);
        nhdr  = hdr_len(f);
        mark  = 1'b1;
        if (nhdr != 0 && !noisy && gen_fmt == f && $urandom_range(0, 3) == 0) begin
            // repeat the previous header unchanged
            for (k = 0; k < 5; k++) hb[k] = gen_hdr[k];
        end else begin
            for (k = 0; k < 5; k++) hb[k] = 8'($urandom_range(0, 255));
            if (noisy) begin
                gen_bps = $urandom_range(2, 3);
                gen_chs = $urandom_range(1, 8);
            end else begin
                case (f)
                    lpcm_dp_pkg::FMT_BLURAY: begin
                        case ($urandom_range(0, 9))
                            0:       begin hb[2][7:4] = 4'h1; gen_chs = 1; end
                            1:       begin hb[2][7:4] = 4'h3; gen_chs = 2; end
                            2:       begin hb[2][7:4] = 4'h4; gen_chs = 3; end
                            3:       begin hb[2][7:4] = 4'h5; gen_chs = 3; end
                            4:       begin hb[2][7:4] = 4'h6; gen_chs = 4; end
                            5:       begin hb[2][7:4] = 4'h7; gen_chs = 4; end
                            6:       begin hb[2][7:4] = 4'h8; gen_chs = 5; end
                            7:       begin hb[2][7:4] = 4'h9; gen_chs = 6; end
                            8:       begin hb[2][7:4] = 4'hA; gen_chs = 7; end
                            default: begin hb[2][7:4] = 4'hB; gen_chs = 8; end
                        endcase
                        case ($urandom_range(0, 2))
                            0:       hb[2][3:0] = 4'h1;
                            1:       hb[2][3:0] = 4'h4;
                            default: hb[2][3:0] = 4'h5;
                        endcase
                        hb[3][7:6] = 2'($urandom_range(1, 3));
                        gen_bps = (hb[3][7:6] == 2'd1) ? 2 : 3;
                    end
                    lpcm_dp_pkg::FMT_DVD: begin
                        gen_bps = (hb[3][7:6] == 2'd1 || hb[3][7:6] == 2'd2) ? 3 : 2;
                        gen_chs = hb[3][2:0] + 1;
                    end
                    lpcm_dp_pkg::FMT_1394: begin
                        hb[3][7:6] = 2'd0;
                        hb[3][5:3] = 3'($urandom_range(1, 2));
                        hb[3][2:0] = 3'($urandom_range(0, 1));
                        gen_bps = 2;
                        gen_chs = 2;
                    end
                    default: ;
                endcase
            end
        end
        for (k = 0; k < 5; k++) gen_hdr[k] = hb[k];
        gen_fmt = f;
        for (k = 0; k < nhdr; k++) begin
            push_byte(hb[k], mark);
            mark = 1'b0;
        end
        nfr = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
        for (k = 0; k < nfr; k++) begin
            // loud frames drive the downmix into saturation
            mode = $urandom_range(0, 4);
            for (j = 0; j < gen_chs; j++) push_sample(mode, mark);
        end
        // partial trailing frame, dropped by the next mark
        tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, gen_bps * gen_chs - 1) : 0;
        for (k = 0; k < tail; k++) begin
            push_byte(8'($urandom_range(0, 255)), mark);
            mark = 1'b0;
        end
    endtask

    // ---------------- driver ----------------
    int unsigned src_mode   = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned bytes_taken = 0;
    lpcm_dp_pkg::t_in drv_next;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                depack_byte(i_in_data);
                bytes_taken++;
            end
            // hold a stalled transfer
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    drv_next = byte_q.pop_front();
                    i_in_data  <= drv_next;
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        case (src_mode)
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(0, 3);
                            default: gap_left = $urandom_range(1, 12);
                        endcase
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver stall pattern ----------------
    int unsigned sink_mode  = 0;
    int unsigned stall_left = 0;
    logic        stall_hi   = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            case (sink_mode)
                0: i_out_stall <= 1'b0;
                1: begin
                    if (stall_left > 0) begin
                        stall_left--;
                    end else begin
                        stall_hi   = !stall_hi;
                        stall_left = stall_hi ? $urandom_range(0, 5) : $urandom_range(0, 15);
                    end
                    i_out_stall <= stall_hi;
                end
                default: i_out_stall <= ($urandom_range(0, 2) != 0);
            endcase
        end
    end

    // ---------------- monitor ----------------
    int unsigned frames_seen = 0;
    int unsigned fail_cnt    = 0;
    lpcm_dp_pkg::t_out mon_want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            frames_seen++;
            if (stereo_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_SHOWN)
                    $display("frame %0d unexpected: L=%0d R=%0d rate=%0d wid=%0d ch=%0d err=%0d",
                             frames_seen, o_out_data.left_sample, o_out_data.right_sample,
                             o_out_data.rate_code, o_out_data.width_code,
                             o_out_data.channel_count, o_out_data.header_error);
            end else begin
                mon_want = stereo_q.pop_front();
                if (o_out_data.left_sample   !== mon_want.left_sample   ||
                    o_out_data.right_sample  !== mon_want.right_sample  ||
                    o_out_data.rate_code     !== mon_want.rate_code     ||
                    o_out_data.width_code    !== mon_want.width_code    ||
                    o_out_data.channel_count !== mon_want.channel_count ||
                    o_out_data.header_error  !== mon_want.header_error) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_SHOWN) begin
                        $display("frame %0d mismatch: exp L=%0d R=%0d rate=%0d wid=%0d %s%0d",
                                 frames_seen, mon_want.left_sample, mon_want.right_sample,
                                 mon_want.rate_code, mon_want.width_code, "ch=",
                                 mon_want.channel_count);
                        $display("               exp err=%0d", mon_want.header_error);
                        $display("               got L=%0d R=%0d rate=%0d wid=%0d ch=%0d err=%0d",
                                 o_out_data.left_sample, o_out_data.right_sample,
                                 o_out_data.rate_code, o_out_data.width_code,
                                 o_out_data.channel_count, o_out_data.header_error);
                    end
                end
            end
        end
    end

    // ---------------- run limit ----------------
    int unsigned cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d frames still expected",
                     cycle_cnt, stereo_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- sequencing ----------------
    task automatic wait_for_idle();
        while (byte_q.size() != 0 || i_in_valid || stereo_q.size() != 0) @(posedge i_clk);
        // let header bytes and partial frames clear the pipeline
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_format(logic [1:0] f);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= f;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        fmt_sel = f;
    endtask

    logic [1:0]  fmt_plan [0:NUM_PHASES-1];
    int unsigned phase_start;

    initial begin
        depack_reset();
        fmt_plan[0] = lpcm_dp_pkg::FMT_BLURAY;
        fmt_plan[1] = lpcm_dp_pkg::FMT_DVD;
        fmt_plan[2] = lpcm_dp_pkg::FMT_1394;
        fmt_plan[3] = FMT_RAW;
        fmt_plan[4] = lpcm_dp_pkg::FMT_BLURAY;
        fmt_plan[5] = lpcm_dp_pkg::FMT_1394;
        fmt_plan[6] = lpcm_dp_pkg::FMT_DVD;
        fmt_plan[7] = lpcm_dp_pkg::FMT_BLURAY;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // bytes before any mark form a header; all zero matches the reset header
        repeat (4) push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0); push_byte(8'h00, 1'b0);
        // mono, 16 bit, 48 kHz
        push_byte(8'h00, 1'b1); push_byte(8'h00, 1'b0);
        push_byte(8'h11, 1'b0); push_byte(8'h40, 1'b0);
        push_byte(8'h80, 1'b0); push_byte(8'h00, 1'b0);
        // half a frame, cut by the next mark
        push_byte(8'h12, 1'b0);
        // bad rate and channel fields fall back to defaults, 24 bit stereo
        push_byte(8'h00, 1'b1); push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'h7F, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hAA, 1'b0);
        push_byte(8'h80, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h55, 1'b0);
        wait_for_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_format(fmt_plan[ph]);
            @(negedge i_clk);
            src_mode  = ph % 3;
            sink_mode = (ph + 1) % 3;
            phase_start = bytes_queued;
            // continue the old packet under the new format
            if ($urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            while (bytes_queued - phase_start < PHASE_ITEMS) gen_packet(fmt_plan[ph]);
            wait_for_idle();
        end

        $display("Sent %0d bytes over %0d header format phases, checked %0d stereo frames",
                 bytes_taken, NUM_PHASES, frames_seen);
        $display("Input gaps and output stalls varied per phase, %0d mismatches", fail_cnt);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
sv/lpcm_dp_pkg.sv
sv/lpcm_dp_parse.sv
sv/lpcm_dp_mix.sv
sv/lpcm_depacketizer_stereo.sv
verif/lpcm_depacketizer_stereo_test.sv
